// ----- hdl/esc_pkg.sv -----
// Shared constants, types and the month-start table for the epoch-seconds-to-calendar block.
// Used by every module under hdl except esc_checker; has no dependencies of its own.
package esc_pkg;

  // Pipeline depth: every request spends this many register stages in the block.
  localparam int unsigned NUM_STAGES = 8;

  // Calendar constants.
  localparam int unsigned SECS_PER_MIN      = 60;
  localparam int unsigned HOURS_PER_DAY     = 24;
  localparam int unsigned DAYS_PER_WEEK     = 7;
  localparam int unsigned WEEKDAY_OF_EPOCH  = 4;
  localparam int unsigned DAYS_1968_TO_1970 = 366 + 365;
  localparam int unsigned DAYS_PER_CYCLE    = (4 * 365) + 1;
  localparam int unsigned DAYS_JAN_FEB      = 31 + 28;
  localparam int unsigned DAYS_PER_YEAR     = 365;
  localparam int unsigned BASE_YEAR         = 68;
  localparam int unsigned NUM_MONTHS        = 12;

  // Reciprocals for division by constants. Each is ceil(2^S / d) and is exact over the
  // operand range used at that stage.
  localparam logic [30:0] RECIP_15_A  = 31'd1145324613; // x < 2^30, shift 34
  localparam logic [25:0] RECIP_15_B  = 26'd35791395;   // x < 2^25, shift 29
  localparam logic [18:0] RECIP_3     = 19'd349526;     // x < 2^18, shift 20
  localparam logic [16:0] RECIP_7     = 17'd74899;      // x < 2^16, shift 19
  localparam logic [16:0] RECIP_1461  = 17'd91868;      // x < 2^16, shift 27
  localparam logic [16:0] RECIP_365   = 17'd91930;      // x < 2^16, shift 25

  // Time-of-day fields carried alongside the date computation.
  typedef struct packed {
    logic [5:0] second;
    logic [5:0] minute;
    logic [4:0] hour;
  } clock_t;

  // Day of the year at which each month starts (non-leap numbering).
  function automatic logic [8:0] month_start(input logic [3:0] month);
    logic [8:0] start;
    case (month)
      4'd0:    start = 9'd0;
      4'd1:    start = 9'd31;
      4'd2:    start = 9'd59;
      4'd3:    start = 9'd90;
      4'd4:    start = 9'd120;
      4'd5:    start = 9'd151;
      4'd6:    start = 9'd181;
      4'd7:    start = 9'd212;
      4'd8:    start = 9'd243;
      4'd9:    start = 9'd273;
      4'd10:   start = 9'd304;
      4'd11:   start = 9'd334;
      default: start = 9'd0;
    endcase
    return start;
  endfunction

endpackage

// ----- hdl/esc_time_split.sv -----
// Splits the seconds count into second, minute, total hours and whole days (stages 1 to 3).
// Depends on esc_pkg for the reciprocal constants and SECS_PER_MIN.
module esc_time_split (
  input  logic        clk_i,
  input  logic        en_i,
  input  logic [31:0] epoch_seconds_i,
  output logic [5:0]  second_o,
  output logic [5:0]  minute_o,
  output logic [20:0] hours_o,
  output logic [15:0] days_o
);

  logic [31:0] secs1_q;
  logic [26:0] mins1_q;
  logic [60:0] prod1;

  logic [5:0]  sec2_q, sec2_d;
  logic [26:0] mins2_q;
  logic [20:0] hours2_q;
  logic [50:0] prod2;
  logic [31:0] sec_diff;

  logic [5:0]  sec3_q;
  logic [5:0]  min3_q, min3_d;
  logic [20:0] hours3_q;
  logic [15:0] days3_q;
  logic [36:0] prod3;
  logic [26:0] min_diff;

  // Stage 1: total minutes = seconds / 60 = (seconds / 4) / 15.
  assign prod1 = 61'(epoch_seconds_i[31:2]) * 61'(esc_pkg::RECIP_15_A);

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      secs1_q <= epoch_seconds_i;
      mins1_q <= prod1[60:34];
    end
  end

  // Stage 2: second within the minute, and total hours = minutes / 60.
  assign sec_diff = secs1_q - (32'(mins1_q) * 32'(esc_pkg::SECS_PER_MIN));
  assign sec2_d   = sec_diff[5:0];
  assign prod2    = 51'(mins1_q[26:2]) * 51'(esc_pkg::RECIP_15_B);

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      sec2_q   <= sec2_d;
      mins2_q  <= mins1_q;
      hours2_q <= prod2[49:29];
    end
  end

  // Stage 3: minute within the hour, and whole days = hours / 24 = (hours / 8) / 3.
  assign min_diff = mins2_q - (27'(hours2_q) * 27'(esc_pkg::SECS_PER_MIN));
  assign min3_d   = min_diff[5:0];
  assign prod3    = 37'(hours2_q[20:3]) * 37'(esc_pkg::RECIP_3);

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      sec3_q   <= sec2_q;
      min3_q   <= min3_d;
      hours3_q <= hours2_q;
      days3_q  <= prod3[35:20];
    end
  end

  assign second_o = sec3_q;
  assign minute_o = min3_q;
  assign hours_o  = hours3_q;
  assign days_o   = days3_q;

endmodule

// ----- hdl/esc_date_calc.sv -----
// Turns the day count into hour, weekday, year, month and day of month (stages 4 to 8).
// Depends on esc_pkg for constants, the clock_t type and the month-start table.
module esc_date_calc (
  input  logic        clk_i,
  input  logic        en_i,
  input  logic [5:0]  second_i,
  input  logic [5:0]  minute_i,
  input  logic [20:0] hours_i,
  input  logic [15:0] days_i,
  output logic [5:0]  second_o,
  output logic [5:0]  minute_o,
  output logic [4:0]  hour_o,
  output logic [2:0]  weekday_o,
  output logic [7:0]  year_since_1900_o,
  output logic [3:0]  month_o,
  output logic [4:0]  day_of_month_o
);

  // Stage 4 signals.
  esc_pkg::clock_t clk4_q, clk4_d;
  logic [20:0] hour_diff;
  logic [15:0] wk_base, day68;
  logic [33:0] prod_wk, prod_lp;
  logic [15:0] wk_base4_q, day68_4_q;
  logic [14:0] weeks4_q;
  logic [5:0]  leaps4_q;

  // Stage 5 signals.
  esc_pkg::clock_t clk5_q;
  logic [15:0] wk_diff;
  logic [2:0]  wday5_q;
  logic [15:0] cycle_base;
  logic [10:0] cycle_day;
  logic        past_feb;
  logic [15:0] yday_total5_q, yday_total5_d;
  logic        short_search5_q;

  // Stage 6 signals.
  esc_pkg::clock_t clk6_q;
  logic [2:0]  wday6_q;
  logic [15:0] yday_total6_q;
  logic        short_search6_q;
  logic [32:0] prod_yr;
  logic [7:0]  years6_q;

  // Stage 7 signals.
  esc_pkg::clock_t clk7_q;
  logic [2:0]  wday7_q;
  logic        short_search7_q;
  logic [15:0] yday_diff;
  logic [8:0]  yday7_q;
  logic [7:0]  year7_q, year7_d;

  // Stage 8 signals.
  logic [3:0]  month_d;
  logic [8:0]  day_diff;
  esc_pkg::clock_t clk8_q;
  logic [2:0]  wday8_q;
  logic [7:0]  year8_q;
  logic [3:0]  month8_q;
  logic [4:0]  mday8_q;

  // Stage 4: hour of day, and quotients for the weekday and the four-year cycle.
  assign hour_diff    = hours_i - (21'(days_i) * 21'(esc_pkg::HOURS_PER_DAY));
  assign clk4_d.second = second_i;
  assign clk4_d.minute = minute_i;
  assign clk4_d.hour   = hour_diff[4:0];
  assign wk_base      = days_i + 16'(esc_pkg::WEEKDAY_OF_EPOCH);
  assign day68        = days_i + 16'(esc_pkg::DAYS_1968_TO_1970);
  assign prod_wk      = 34'(wk_base) * 34'(esc_pkg::RECIP_7);
  assign prod_lp      = 34'(day68) * 34'(esc_pkg::RECIP_1461);

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      clk4_q     <= clk4_d;
      wk_base4_q <= wk_base;
      day68_4_q  <= day68;
      weeks4_q   <= prod_wk[33:19];
      leaps4_q   <= prod_lp[32:27];
    end
  end

  // Stage 5: weekday, day within the cycle and the leap-day correction.
  assign wk_diff    = wk_base4_q - (16'(weeks4_q) * 16'(esc_pkg::DAYS_PER_WEEK));
  assign cycle_base = 16'(leaps4_q) * 16'(esc_pkg::DAYS_PER_CYCLE);
  assign cycle_day  = 11'(day68_4_q - cycle_base);
  assign past_feb   = cycle_day > 11'(esc_pkg::DAYS_JAN_FEB);
  assign yday_total5_d = day68_4_q - 16'(leaps4_q) - 16'(past_feb);

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      clk5_q          <= clk4_q;
      wday5_q         <= wk_diff[2:0];
      yday_total5_q   <= yday_total5_d;
      short_search5_q <= ~past_feb;
    end
  end

  // Stage 6: whole years since 1968.
  assign prod_yr = 33'(yday_total5_q) * 33'(esc_pkg::RECIP_365);

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      clk6_q          <= clk5_q;
      wday6_q         <= wday5_q;
      yday_total6_q   <= yday_total5_q;
      short_search6_q <= short_search5_q;
      years6_q        <= prod_yr[32:25];
    end
  end

  // Stage 7: day within the year and the calendar year.
  assign yday_diff = yday_total6_q - (16'(years6_q) * 16'(esc_pkg::DAYS_PER_YEAR));
  assign year7_d   = years6_q + 8'(esc_pkg::BASE_YEAR);

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      clk7_q          <= clk6_q;
      wday7_q         <= wday6_q;
      short_search7_q <= short_search6_q;
      yday7_q         <= yday_diff[8:0];
      year7_q         <= year7_d;
    end
  end

  // Stage 8: month search. In the first two months of a leap year only January and
  // February are candidates, so the leap day lands on February 29.
  always_comb begin
    month_d = 4'd0;
    if (short_search7_q) begin
      if (esc_pkg::month_start(4'd1) <= yday7_q) begin
        month_d = 4'd1;
      end
    end else begin
      for (int m = 1; m < esc_pkg::NUM_MONTHS; m++) begin
        if (esc_pkg::month_start(4'(m)) <= yday7_q) begin
          month_d = month_d + 4'd1;
        end
      end
    end
  end

  assign day_diff = yday7_q - esc_pkg::month_start(month_d) + 9'd1;

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      clk8_q   <= clk7_q;
      wday8_q  <= wday7_q;
      year8_q  <= year7_q;
      month8_q <= month_d;
      mday8_q  <= day_diff[4:0];
    end
  end

  assign second_o          = clk8_q.second;
  assign minute_o          = clk8_q.minute;
  assign hour_o            = clk8_q.hour;
  assign weekday_o         = wday8_q;
  assign year_since_1900_o = year8_q;
  assign month_o           = month8_q;
  assign day_of_month_o    = mday8_q;

endmodule

// ----- hdl/epoch_seconds_to_calendar.sv -----
// An accepted request passes through the register stages in order to its result on the output.
// Throughput: one request per cycle; the 8-stage pipeline only halts while a result is stalled.
// Each stage holds at most one request, with a valid bit that moves along with the data.
// Reset (rst_ni, asynchronous, active low) clears only the stage valid bits.
// Uses esc_pkg, esc_time_split (stages 1 to 3) and esc_date_calc (stages 4 to 8).
module epoch_seconds_to_calendar (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  output logic        in_stall_o,
  input  logic [31:0] epoch_seconds_i,
  output logic        out_valid_o,
  input  logic        out_stall_i,
  output logic [5:0]  second_o,
  output logic [5:0]  minute_o,
  output logic [4:0]  hour_o,
  output logic [2:0]  weekday_o,
  output logic [7:0]  year_since_1900_o,
  output logic [3:0]  month_o,
  output logic [4:0]  day_of_month_o
);

  logic [esc_pkg::NUM_STAGES-1:0] valid_q, valid_d;
  logic        advance;
  logic [5:0]  sec_mid, min_mid;
  logic [20:0] hours_mid;
  logic [15:0] days_mid;

  // The whole pipeline moves unless the finished result at the end is stalled.
  assign advance    = ~(valid_q[esc_pkg::NUM_STAGES-1] & out_stall_i);
  assign in_stall_o = ~advance;

  // Valid bits shift with the data.
  assign valid_d = advance ? {valid_q[esc_pkg::NUM_STAGES-2:0], in_valid_i} : valid_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= '0;
    end else begin
      valid_q <= valid_d;
    end
  end

  assign out_valid_o = valid_q[esc_pkg::NUM_STAGES-1];

  esc_time_split u_time (
    .clk_i           (clk_i),
    .en_i            (advance),
    .epoch_seconds_i (epoch_seconds_i),
    .second_o        (sec_mid),
    .minute_o        (min_mid),
    .hours_o         (hours_mid),
    .days_o          (days_mid)
  );

  esc_date_calc u_date (
    .clk_i             (clk_i),
    .en_i              (advance),
    .second_i          (sec_mid),
    .minute_i          (min_mid),
    .hours_i           (hours_mid),
    .days_i            (days_mid),
    .second_o          (second_o),
    .minute_o          (minute_o),
    .hour_o            (hour_o),
    .weekday_o         (weekday_o),
    .year_since_1900_o (year_since_1900_o),
    .month_o           (month_o),
    .day_of_month_o    (day_of_month_o)
  );

endmodule

// ----- hdl/esc_checker.sv -----
// Port-level checks for epoch_seconds_to_calendar, attached by the bind at the end.
// Sees only the top-level ports; has no other dependencies.
module esc_checker (
  input logic        clk_i,
  input logic        rst_ni,
  input logic        in_valid_i,
  input logic        in_stall_o,
  input logic [31:0] epoch_seconds_i,
  input logic        out_valid_o,
  input logic        out_stall_i,
  input logic [5:0]  second_o,
  input logic [5:0]  minute_o,
  input logic [4:0]  hour_o,
  input logic [2:0]  weekday_o,
  input logic [7:0]  year_since_1900_o,
  input logic [3:0]  month_o,
  input logic [4:0]  day_of_month_o
);

  // The input side is held back only by a stalled result at the output.
  a_stall_cause: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_stall_o |-> (out_valid_o && out_stall_i))
    else $error("input stalled without a stalled result");

  // A stalled result stays on the output unchanged.
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && out_stall_i) |=>
      (out_valid_o && $stable(second_o) && $stable(minute_o) && $stable(hour_o) &&
       $stable(weekday_o) && $stable(year_since_1900_o) && $stable(month_o) &&
       $stable(day_of_month_o)))
    else $error("stalled result changed");

  // Time-of-day fields stay inside their ranges.
  a_time_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> (second_o < 6'd60 && minute_o < 6'd60 && hour_o < 5'd24 &&
                     weekday_o < 3'd7))
    else $error("time field out of range");

  // Date fields stay inside their ranges.
  a_date_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> (year_since_1900_o >= 8'd70 && year_since_1900_o <= 8'd206 &&
                     month_o < 4'd12 && day_of_month_o != 5'd0))
    else $error("date field out of range");

  // The handshake outputs are never unknown once out of reset.
  a_known: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !$isunknown({out_valid_o, in_stall_o}))
    else $error("handshake output unknown");

endmodule

bind epoch_seconds_to_calendar esc_checker u_esc_checker (.*);
